// ===== hw/rtl/tth_pkg.sv =====
// Shared widths and latency constants for the triangle tangent pipeline.
`default_nettype none
package tth_pkg;
  localparam int COORD_BITS = 16;               // signed position component width
  localparam int DIFF_W     = COORD_BITS + 1;   // position edge component
  localparam int UV_W       = 16;
  localparam int UVD_W      = UV_W + 1;         // UV edge component
  localparam int COMP_W     = 16;               // Q1.14 unit component
  localparam int UNIT_FRAC  = 14;
  localparam int UNIT_BITS  = UNIT_FRAC + 1;    // magnitude 0..16384
  localparam int NIN_W      = 31;               // normalizer input component
  localparam int MAG_W      = NIN_W - 1;
  localparam int SQ_W       = 2 * MAG_W;
  localparam int SUM_W      = SQ_W + 2;
  localparam int ACC_W      = 96;               // search accumulators
  localparam int NORM_LAT   = UNIT_BITS + 4;    // normalizer register stages
endpackage
`default_nettype wire

// ===== hw/rtl/triangle_tangent_handedness_top.sv =====
// Top level: per-triangle unit tangent, handedness and degenerate flag.
`default_nettype none
// Fully pipelined: one triangle request accepted every clock, passing the edge stage,
// two tiers of exact normalizers of 19 stages each, and the basis and cross/dot
// stages. The whole pipeline holds while a result waits on out_tready; nothing is
// dropped or repeated. Tangent components are Q1.14 rounded to nearest, ties away
// from zero; a zero UV determinant gives a zero tangent, handedness 0, degenerate 1.
module triangle_tangent_handedness_top
  import tth_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // pos_a[47:0], pos_b[95:48], pos_c[143:96], uv_a[175:144], uv_b[207:176],
  // uv_c[239:208], face_normal[287:240]
  input  logic [287:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // tangent_x[15:0], tangent_y[31:16], tangent_z[47:32], handedness[48], zero pad
  output logic [55:0]  out_tdata,
  // degenerate[0]
  output logic         out_tuser
);

  localparam int ST_D   = 1;
  localparam int ST_N1  = ST_D + NORM_LAT;
  localparam int ST_P3  = ST_N1 + 3;
  localparam int ST_N2  = ST_P3 + NORM_LAT;
  localparam int ST_OUT = ST_N2 + 4;

  logic en;
  logic [ST_OUT:1] vld_r;

  assign en         = !vld_r[ST_OUT] || out_tready;
  assign in_tready  = en;
  assign out_tvalid = vld_r[ST_OUT];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[ST_OUT-1:1], in_tvalid};
    end
  end

  // unpack and edges
  logic [63:0] pw [3];
  logic signed [COORD_BITS-1:0] pc [3][3];
  logic signed [UV_W-1:0] uvc [3][2];
  logic signed [NIN_W-1:0] e1_in [3], e2_in [3], u1_in [3], u2_in [3];

  always_comb begin
    for (int v = 0; v < 3; v++) begin
      pw[v] = {16'b0, in_tdata[v*48 +: 48]};
      for (int i = 0; i < 3; i++) begin
        pc[v][i] = pw[v][i*COORD_BITS +: COORD_BITS];
      end
      for (int i = 0; i < 2; i++) begin
        uvc[v][i] = in_tdata[144 + v*32 + i*16 +: 16];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        e1_in[i] <= NIN_W'(DIFF_W'(pc[1][i]) - DIFF_W'(pc[0][i]));
        e2_in[i] <= NIN_W'(DIFF_W'(pc[2][i]) - DIFF_W'(pc[0][i]));
      end
      for (int i = 0; i < 2; i++) begin
        u1_in[i] <= NIN_W'(UVD_W'(uvc[1][i]) - UVD_W'(uvc[0][i]));
        u2_in[i] <= NIN_W'(UVD_W'(uvc[2][i]) - UVD_W'(uvc[0][i]));
      end
      u1_in[2] <= '0;
      u2_in[2] <= '0;
    end
  end

  logic signed [COMP_W-1:0] e1 [3], e2 [3], u1 [3], u2 [3];

  tth_norm u_norm_e1 (.clk(clk), .en(en), .vec_i(e1_in), .vec_o(e1));
  tth_norm u_norm_e2 (.clk(clk), .en(en), .vec_i(e2_in), .vec_o(e2));
  tth_norm u_norm_u1 (.clk(clk), .en(en), .vec_i(u1_in), .vec_o(u1));
  tth_norm u_norm_u2 (.clk(clk), .en(en), .vec_i(u2_in), .vec_o(u2));

  // determinant and raw basis
  logic signed [31:0] dp0_r, dp1_r;
  logic signed [31:0] ta_r [3], tb_r [3], ba_r [3], bb_r [3];
  logic signed [32:0] det_r;
  logic signed [32:0] tr_r [3], br_r [3];
  logic signed [NIN_W-1:0] t_in [3], b_in [3];
  logic deg_p3_r;

  always_ff @(posedge clk) begin
    if (en) begin
      dp0_r <= u1[0] * u2[1];
      dp1_r <= u1[1] * u2[0];
      for (int i = 0; i < 3; i++) begin
        ta_r[i] <= u2[1] * e1[i];
        tb_r[i] <= u1[1] * e2[i];
        ba_r[i] <= u1[0] * e2[i];
        bb_r[i] <= u2[0] * e1[i];
      end
      det_r <= 33'(dp0_r) - 33'(dp1_r);
      for (int i = 0; i < 3; i++) begin
        tr_r[i] <= 33'(ta_r[i]) - 33'(tb_r[i]);
        br_r[i] <= 33'(ba_r[i]) - 33'(bb_r[i]);
      end
      deg_p3_r <= (det_r == '0);
      for (int i = 0; i < 3; i++) begin
        t_in[i] <= det_r[32] ? NIN_W'(-tr_r[i]) : NIN_W'(tr_r[i]);
        b_in[i] <= det_r[32] ? NIN_W'(-br_r[i]) : NIN_W'(br_r[i]);
      end
    end
  end

  logic signed [COMP_W-1:0] tv [3], bv [3];

  tth_norm u_norm_t (.clk(clk), .en(en), .vec_i(t_in), .vec_o(tv));
  tth_norm u_norm_b (.clk(clk), .en(en), .vec_i(b_in), .vec_o(bv));

  // side data delay lines
  logic [47:0] nrm_d_r [ST_D:ST_N2];
  logic        deg_d_r [ST_P3+1:ST_OUT-1];

  always_ff @(posedge clk) begin
    if (en) begin
      nrm_d_r[ST_D] <= in_tdata[287:240];
      for (int s = ST_D + 1; s <= ST_N2; s++) begin
        nrm_d_r[s] <= nrm_d_r[s-1];
      end
      deg_d_r[ST_P3+1] <= deg_p3_r;
      for (int s = ST_P3 + 2; s <= ST_OUT - 1; s++) begin
        deg_d_r[s] <= deg_d_r[s-1];
      end
    end
  end

  // cross and dot
  logic signed [UV_W-1:0]   nv [3];
  logic signed [31:0]       cp_r [6];
  logic signed [32:0]       cr_r [3];
  logic signed [48:0]       dt_r [3];
  logic signed [COMP_W-1:0] t1_r [3], t2_r [3], t3_r [3];
  logic signed [COMP_W-1:0] b1_r [3], b2_r [3];
  logic signed [50:0]       dot;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      nv[i] = nrm_d_r[ST_N2][i*16 +: 16];
    end
    dot = 51'(dt_r[0]) + 51'(dt_r[1]) + 51'(dt_r[2]);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cp_r[0] <= nv[1] * tv[2];
      cp_r[1] <= nv[2] * tv[1];
      cp_r[2] <= nv[2] * tv[0];
      cp_r[3] <= nv[0] * tv[2];
      cp_r[4] <= nv[0] * tv[1];
      cp_r[5] <= nv[1] * tv[0];
      for (int i = 0; i < 3; i++) begin
        cr_r[i] <= 33'(cp_r[2*i]) - 33'(cp_r[2*i+1]);
        dt_r[i] <= cr_r[i] * b2_r[i];
        t1_r[i] <= tv[i];
        t2_r[i] <= t1_r[i];
        t3_r[i] <= t2_r[i];
        b1_r[i] <= bv[i];
        b2_r[i] <= b1_r[i];
      end
      if (deg_d_r[ST_OUT-1]) begin
        out_tdata <= 56'(1'b0);
      end else begin
        out_tdata <= {7'b0, dot[50], t3_r[2], t3_r[1], t3_r[0]};
      end
      out_tuser <= deg_d_r[ST_OUT-1];
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/tth_norm.sv =====
// Pipelined exact 3-vector normalizer to Q1.14, one bit of each component per stage.
`default_nettype none
module tth_norm
  import tth_pkg::*;
(
  input  logic                     clk,
  input  logic                     en,
  input  logic signed [NIN_W-1:0]  vec_i [3],
  output logic signed [COMP_W-1:0] vec_o [3]
);

  logic [MAG_W-1:0]        mag_r  [3];
  logic [2:0]              neg_a_r;
  logic [SQ_W-1:0]         sq_r   [3];
  logic [2:0]              neg_q_r;

  // stage 0 is the search setup, stage k+1 follows search step k
  logic signed [ACC_W-1:0] x_r   [UNIT_BITS+1][3];
  logic signed [ACC_W-1:0] z_r   [UNIT_BITS+1][3];
  logic signed [ACC_W-1:0] rr_r  [UNIT_BITS+1][3];
  logic [UNIT_BITS-1:0]    m_r   [UNIT_BITS+1][3];
  logic [2:0]              neg_r [UNIT_BITS+1];
  logic [SUM_W-1:0]        s_r   [UNIT_BITS+1];

  logic signed [ACC_W-1:0] s_ext [UNIT_BITS];
  logic signed [ACC_W-1:0] tst   [UNIT_BITS][3];
  logic                    take  [UNIT_BITS][3];
  logic signed [NIN_W-1:0] abs_v [3];
  logic [SUM_W-1:0]        s_sum;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      abs_v[i] = vec_i[i][NIN_W-1] ? -vec_i[i] : vec_i[i];
    end
    s_sum = SUM_W'(sq_r[0]) + SUM_W'(sq_r[1]) + SUM_W'(sq_r[2]);
  end

  // Candidate m' = m + 2^j: (2m'-1)^2 s = X + (2m-1)s*2^(j+2) + s*2^(2j+2)
  always_comb begin
    for (int k = 0; k < UNIT_BITS; k++) begin
      s_ext[k] = $signed(ACC_W'(s_r[k]));
      for (int i = 0; i < 3; i++) begin
        tst[k][i]  = x_r[k][i] + (z_r[k][i] <<< (UNIT_BITS + 1 - k))
                     + (s_ext[k] <<< (2 * (UNIT_BITS - k)));
        take[k][i] = (tst[k][i] <= rr_r[k][i]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        mag_r[i]   <= abs_v[i][MAG_W-1:0];
        neg_a_r[i] <= vec_i[i][NIN_W-1];
        sq_r[i]    <= mag_r[i] * mag_r[i];
      end
      neg_q_r     <= neg_a_r;

      s_r[0]   <= s_sum;
      neg_r[0] <= neg_q_r;
      for (int i = 0; i < 3; i++) begin
        x_r[0][i]  <= $signed(ACC_W'(s_sum));
        z_r[0][i]  <= -$signed(ACC_W'(s_sum));
        rr_r[0][i] <= $signed(ACC_W'(sq_r[i]) << (2 * UNIT_FRAC + 2));
        m_r[0][i]  <= '0;
      end

      for (int k = 0; k < UNIT_BITS; k++) begin
        s_r[k+1]   <= s_r[k];
        neg_r[k+1] <= neg_r[k];
        for (int i = 0; i < 3; i++) begin
          rr_r[k+1][i] <= rr_r[k][i];
          if (take[k][i]) begin
            x_r[k+1][i] <= tst[k][i];
            z_r[k+1][i] <= z_r[k][i] + (s_ext[k] <<< (UNIT_BITS - k));
            m_r[k+1][i] <= m_r[k][i] | (UNIT_BITS'(1) << (UNIT_BITS - 1 - k));
          end else begin
            x_r[k+1][i] <= x_r[k][i];
            z_r[k+1][i] <= z_r[k][i];
            m_r[k+1][i] <= m_r[k][i];
          end
        end
      end

      for (int i = 0; i < 3; i++) begin
        if (s_r[UNIT_BITS] == '0) begin
          vec_o[i] <= '0;
        end else if (neg_r[UNIT_BITS][i]) begin
          vec_o[i] <= -$signed(COMP_W'(m_r[UNIT_BITS][i]));
        end else begin
          vec_o[i] <= $signed(COMP_W'(m_r[UNIT_BITS][i]));
        end
      end
    end
  end

endmodule
`default_nettype wire

// ===== bench/triangle_tangent_handedness_top_tb.sv =====
// Self-checking bench for the triangle tangent pipeline: directed table, then random triangles.
`timescale 1ns / 100ps
module triangle_tangent_handedness_top_tb;
  import tth_pkg::*;

  localparam int N_RANDOM = 1800;
  localparam int DRAIN_CYCLES = 80;

  typedef struct packed {
    logic [15:0] tz;
    logic [15:0] ty;
    logic [15:0] tx;
    logic        hand;
    logic        degen;
  } tangent_t;

  typedef struct {
    logic [287:0] data;
    logic         known;   // expected result typed in
    tangent_t     res;
  } stim_row_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [287:0] in_tdata = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [55:0]  out_tdata;
  logic         out_tuser;

  tangent_t  tangent_q[$];
  stim_row_t dir_tab[$];
  int        n_err = 0;
  int        n_seen = 0;
  int        n_degen = 0;
  int        n_neg = 0;
  bit        sending = 1'b1;

  always #6 clk = ~clk;

  triangle_tangent_handedness_top u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser)
  );

  // round(c * 2^14 / sqrt(s)) ties away from zero, by bisection on exact integers
  function automatic longint unit_comp(longint c, longint unsigned s);
    logic [127:0] lhs, rhs;
    longint unsigned mag, lo, hi, mid, k;
    mag = (c < 0) ? -c : c;
    lo = 0;
    hi = 16384;
    rhs = ({64'd0, mag * mag}) << 30;
    while (lo < hi) begin
      mid = (lo + hi + 1) / 2;
      k = 2 * mid - 1;
      lhs = {64'd0, k * k} * {64'd0, s};
      if (lhs <= rhs) lo = mid;
      else hi = mid - 1;
    end
    return (c < 0) ? -longint'(lo) : longint'(lo);
  endfunction

  function automatic void unit_vec(input longint v[3], input int n, output longint o[3]);
    longint unsigned s;
    s = 0;
    for (int i = 0; i < n; i++) s += longint'(v[i] < 0 ? -v[i] : v[i]) ** 2;
    for (int i = 0; i < 3; i++) o[i] = (s == 0 || i >= n) ? 0 : unit_comp(v[i], s);
  endfunction

  function automatic longint sx16(logic [15:0] r);
    return longint'($signed(r));
  endfunction

  function automatic tangent_t tangent_of(logic [287:0] d);
    longint pa[3], pb[3], pc[3], nv[3], e1r[3], e2r[3], e1[3], e2[3];
    longint u1r[3], u2r[3], u1[3], u2[3], tr[3], br[3], t[3], b[3], cr[3];
    longint det, dp, ua;
    tangent_t r;
    for (int i = 0; i < 3; i++) begin
      pa[i] = sx16(d[i*16 +: 16]);
      pb[i] = sx16(d[48 + i*16 +: 16]);
      pc[i] = sx16(d[96 + i*16 +: 16]);
      nv[i] = sx16(d[240 + i*16 +: 16]);
      e1r[i] = pb[i] - pa[i];
      e2r[i] = pc[i] - pa[i];
      u1r[i] = 0;
      u2r[i] = 0;
    end
    for (int i = 0; i < 2; i++) begin
      ua = sx16(d[144 + i*16 +: 16]);
      u1r[i] = sx16(d[176 + i*16 +: 16]) - ua;
      u2r[i] = sx16(d[208 + i*16 +: 16]) - ua;
    end
    unit_vec(e1r, 3, e1);
    unit_vec(e2r, 3, e2);
    unit_vec(u1r, 2, u1);
    unit_vec(u2r, 2, u2);
    det = u1[0] * u2[1] - u1[1] * u2[0];
    r = '0;
    if (det == 0) begin
      r.degen = 1'b1;
      return r;
    end
    for (int i = 0; i < 3; i++) begin
      tr[i] = u2[1] * e1[i] - u1[1] * e2[i];
      br[i] = u1[0] * e2[i] - u2[0] * e1[i];
      if (det < 0) begin
        tr[i] = -tr[i];
        br[i] = -br[i];
      end
    end
    unit_vec(tr, 3, t);
    unit_vec(br, 3, b);
    cr[0] = nv[1] * t[2] - nv[2] * t[1];
    cr[1] = nv[2] * t[0] - nv[0] * t[2];
    cr[2] = nv[0] * t[1] - nv[1] * t[0];
    dp = cr[0] * b[0] + cr[1] * b[1] + cr[2] * b[2];
    r.tx = t[0][15:0];
    r.ty = t[1][15:0];
    r.tz = t[2][15:0];
    r.hand = (dp < 0);
    return r;
  endfunction

  function automatic logic [47:0] v3(int x, int y, int z);
    return {z[15:0], y[15:0], x[15:0]};
  endfunction

  function automatic logic [31:0] v2(int u, int v);
    return {v[15:0], u[15:0]};
  endfunction

  function automatic logic [287:0] tri_req(logic [47:0] a, logic [47:0] b, logic [47:0] c,
                                           logic [31:0] ta, logic [31:0] tb,
                                           logic [31:0] tc, logic [47:0] n);
    return {n, tc, tb, ta, c, b, a};
  endfunction

  function automatic int gap_len();
    return ($urandom_range(0, 9) < 6) ? 0 :
           ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(10, 60);
  endfunction

  // random triangle: mostly small coordinates so the geometry is well formed
  function automatic logic [287:0] rand_tri();
    logic [287:0] d;
    int sel;
    sel = $urandom_range(0, 9);
    for (int i = 0; i < 9; i++) d[i*32 +: 32] = $urandom;
    if (sel < 6) begin
      for (int i = 0; i < 9; i++)
        d[i*16 +: 16] = 16'($signed($urandom_range(0, 2047)) - 1024);
      for (int i = 0; i < 6; i++)
        d[144 + i*16 +: 16] = 16'($signed($urandom_range(0, 16383)) - 8192);
    end else if (sel < 8) begin
      // repeated vertex, sometimes with repeated (collinear) UVs as well
      d[48 +: 48] = d[0 +: 48];
      if ($urandom_range(0, 1)) d[208 +: 32] = d[176 +: 32];
    end
    return d;
  endfunction

  initial begin
    tangent_t q;
    q = '0;
    // zero everything: degenerate
    dir_tab.push_back('{'0, 1'b1, '{tz:0, ty:0, tx:0, hand:0, degen:1}});
    // every bit set: all UV differences are zero
    dir_tab.push_back('{'1, 1'b1, '{tz:0, ty:0, tx:0, hand:0, degen:1}});
    // axis aligned triangle, u along x, v along y, normal +z
    dir_tab.push_back('{tri_req(v3(0,0,0), v3(256,0,0), v3(0,256,0), v2(0,0),
                        v2(16384,0), v2(0,16384), v3(0,0,16384)), 1'b1,
                        '{tz:0, ty:0, tx:16'd16384, hand:0, degen:0}});
    // same with normal -z: left handed
    dir_tab.push_back('{tri_req(v3(0,0,0), v3(256,0,0), v3(0,256,0), v2(0,0),
                        v2(16384,0), v2(0,16384), v3(0,0,-16384)), 1'b1,
                        '{tz:0, ty:0, tx:16'd16384, hand:1, degen:0}});
    // mirrored UVs: negative determinant
    dir_tab.push_back('{tri_req(v3(0,0,0), v3(256,0,0), v3(0,256,0), v2(0,0),
                        v2(-16384,0), v2(0,16384), v3(0,0,16384)), 1'b0, q});
    // extreme positions and uvs
    dir_tab.push_back('{tri_req(v3(-32768,-32768,-32768), v3(32767,32767,-32768),
                        v3(-32768,32767,32767), v2(-32768,-32768), v2(32767,-32768),
                        v2(-32768,32767), v3(32767,-32768,32767)), 1'b0, q});
    dir_tab.push_back('{tri_req(v3(32767,0,-32768), v3(-32768,0,32767), v3(0,32767,0),
                        v2(32767,32767), v2(-32768,32767), v2(32767,-32768),
                        v3(-32768,-32768,-32768)), 1'b0, q});
    // zero tangent with nonzero determinant: degenerate positions
    dir_tab.push_back('{tri_req(v3(5,5,5), v3(5,5,5), v3(5,5,5), v2(0,0),
                        v2(16384,0), v2(0,16384), v3(0,0,16384)), 1'b1,
                        '{tz:0, ty:0, tx:0, hand:0, degen:0}});
    // zero normal: dot exactly zero
    dir_tab.push_back('{tri_req(v3(0,0,0), v3(0,0,300), v3(0,300,0), v2(100,100),
                        v2(-900,500), v2(700,700), v3(0,0,0)), 1'b0, q});
    // parallel UV difference vectors
    dir_tab.push_back('{tri_req(v3(0,0,0), v3(1,2,3), v3(3,2,1), v2(0,0),
                        v2(100,100), v2(300,300), v3(1,1,1)), 1'b1,
                        '{tz:0, ty:0, tx:0, hand:0, degen:1}});
    // tie rounding cases along diagonals
    dir_tab.push_back('{tri_req(v3(0,0,0), v3(1,1,0), v3(0,1,1), v2(0,0),
                        v2(1,1), v2(-1,1), v3(16384,16384,-16384)), 1'b0, q});
    dir_tab.push_back('{tri_req(v3(-1,-1,-1), v3(1,-1,-1), v3(-1,-1,1), v2(-16384,0),
                        v2(16383,-1), v2(3,16383), v3(0,-16384,0)), 1'b0, q});
  end

  task automatic send(logic [287:0] d);
    in_tdata <= d;
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    tangent_q.push_back(tangent_of(d));
  endtask

  task automatic pause();
    int g;
    g = gap_len();
    if (g > 0) begin
      in_tvalid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  // stimulus
  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (dir_tab[i]) begin
      send(dir_tab[i].data);
      if (dir_tab[i].known && tangent_q[$] !== dir_tab[i].res) begin
        n_err++;
        if (n_err <= 10)
          $display("table row %0d: predictor %h, typed %h", i, tangent_q[$], dir_tab[i].res);
        tangent_q[$] = dir_tab[i].res;
      end
      pause();
    end
    for (int i = 0; i < N_RANDOM; i++) begin
      send(rand_tri());
      pause();
    end
    in_tvalid <= 1'b0;
    sending = 1'b0;
  end

  // result side stall pattern
  initial begin
    int g;
    out_tready <= 1'b0;
    @(posedge rst_n);
    forever begin
      out_tready <= 1'b1;
      repeat ($urandom_range(1, 20)) @(posedge clk);
      g = gap_len();
      if (g > 0) begin
        out_tready <= 1'b0;
        repeat (g) @(posedge clk);
      end
    end
  end

  // result check
  always @(posedge clk) begin
    tangent_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got = {out_tdata[47:0], out_tdata[48], out_tuser};
      n_seen++;
      if (tangent_q.size() == 0) begin
        n_err++;
        if (n_err <= 10) $display("unexpected request result %h", got);
      end else begin
        want = tangent_q.pop_front();
        n_degen += want.degen;
        n_neg += want.hand;
        if (got !== want || out_tdata[55:49] !== '0) begin
          n_err++;
          if (n_err <= 10)
            $display("result %0d: exp tx=%h ty=%h tz=%h h=%b d=%b got tx=%h ty=%h tz=%h h=%b d=%b",
                     n_seen, want.tx, want.ty, want.tz, want.hand, want.degen,
                     got.tx, got.ty, got.tz, got.hand, got.degen);
        end
      end
    end
  end

  initial begin
    @(posedge rst_n);
    wait (!sending && tangent_q.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (tangent_q.size() != 0) n_err++;
    $display("checked %0d triangle results (%0d degenerate, %0d left handed)",
             n_seen, n_degen, n_neg);
    if (n_err == 0) begin
      $display("SUCCESS");
    end else begin
      $display("%0d mismatches", n_err);
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #20000000;
    $display("FAILURE");
    $finish;
  end
endmodule
